// ===== src/hsv2rgb_pkg.sv =====
// shared types, constants and the fraction table for the hsv to rgb pixel converter
`default_nettype none
package hsv2rgb_pkg;

	// fixed point format of saturation and value
	localparam int FRAC_BITS = 8;
	localparam int UNIT_W = FRAC_BITS + 1;
	localparam int ONE = 1 << FRAC_BITS;

	// port widths
	localparam int HUE_W = 9;
	localparam int SV_W = 10;
	localparam int CH_W = 8;

	// hue sectors and the in-sector fraction
	localparam int HUE_PER_SECTOR = 60;
	localparam int RAW_SECTORS = (2 ** HUE_W - 1) / HUE_PER_SECTOR;
	localparam int RAW_SEC_W = $clog2(RAW_SECTORS + 1);
	localparam int REM_W = $clog2(HUE_PER_SECTOR);
	localparam int F_W = 16;
	localparam int F_ONE = 1 << F_W;

	// level arithmetic widths
	localparam int SF_W = UNIT_W + F_W;
	localparam int FC_W = F_W + 1;
	localparam int SG_W = UNIT_W + FC_W;
	localparam int A_W = FRAC_BITS + F_W + 1;
	localparam int VA_W = UNIT_W + A_W;
	localparam int VP_W = 2 * UNIT_W;
	localparam int CV_W = UNIT_W + CH_W;
	localparam int LEVEL_SHIFT = 2 * FRAC_BITS + F_W;

	// request queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t sector;
		logic [UNIT_W-1:0] sat;
		logic [UNIT_W-1:0] val;
		logic [F_W-1:0] frac;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef logic [HUE_PER_SECTOR-1:0][F_W-1:0] frac_tbl_t;

	// floor(rem * 2^16 / 60) for every remainder
	function automatic frac_tbl_t build_frac_tbl();
		frac_tbl_t tbl;
		for (int i = 0; i < HUE_PER_SECTOR; i++) begin
			tbl[i] = F_W'((i << F_W) / HUE_PER_SECTOR);
		end
		return tbl;
	endfunction

	localparam frac_tbl_t FRAC_LUT = build_frac_tbl();

endpackage
`default_nettype wire

// ===== src/hsv2rgb_front.sv =====
// front end: clamps saturation and value, splits hue into sector and fraction
`default_nettype none
module hsv2rgb_front
	import hsv2rgb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [HUE_W-1:0]      hue_degrees,
	input  wire logic signed [SV_W-1:0] saturation,
	input  wire logic signed [SV_W-1:0] brightness,
	input  wire q_status_t             q_status,
	output logic                       push,
	output item_t                      push_item
);

	logic valid_s1;
	item_t item_s1;
	logic accept;
	logic advance;
	logic [RAW_SEC_W-1:0] raw_sector;
	logic [HUE_W-1:0] rem_full;
	logic [REM_W-1:0] rem;
	item_t item_d;

	function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [SV_W-1:0] x);
		int xi;
		xi = int'(x);
		if (xi < 0) begin
			return '0;
		end else if (xi > ONE) begin
			return UNIT_W'(ONE);
		end
		return UNIT_W'(xi);
	endfunction

	// sector count by compare against every boundary
	always_comb begin
		raw_sector = '0;
		for (int k = 1; k <= RAW_SECTORS; k++) begin
			if (int'(hue_degrees) >= k * HUE_PER_SECTOR) begin
				raw_sector = raw_sector + RAW_SEC_W'(1);
			end
		end
	end

	assign rem_full = hue_degrees - HUE_W'(raw_sector * HUE_W'(HUE_PER_SECTOR));
	assign rem = rem_full[REM_W-1:0];

	always_comb begin
		item_d.sat = clamp_unit(saturation);
		item_d.val = clamp_unit(brightness);
		item_d.frac = FRAC_LUT[rem];
		// a full turn and beyond wraps to the red sector
		if (int'(raw_sector) >= 6) begin
			item_d.sector = SEC_R_TO_Y;
		end else begin
			item_d.sector = sector_t'(raw_sector[2:0]);
		end
	end

	assign advance = !valid_s1 || !q_status.full;
	assign busy = !advance;
	assign accept = start && advance;
	assign push = valid_s1 && !q_status.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/hsv2rgb_queue.sv =====
// short request queue between front and back
`default_nettype none
module hsv2rgb_queue
	import hsv2rgb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head_item,
	output q_status_t  status
);

	item_t entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign status.full = (count_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== src/hsv2rgb_back.sv =====
// back end: forms p, q and t, scales to 8 bits and orders the channels
`default_nettype none
module hsv2rgb_back
	import hsv2rgb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire q_status_t  q_status,
	input  wire item_t      head_item,
	output logic            pop,
	output logic            done,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue
);

	localparam logic [A_W-1:0] LEVEL_ONE = A_W'(1) << (FRAC_BITS + F_W);

	// stage 1
	logic valid_s1;
	sector_t sector_s1;
	logic [UNIT_W-1:0] val_s1;
	logic [SF_W-1:0] sf_s1;
	logic [SG_W-1:0] sg_s1;
	logic [VP_W-1:0] vp_s1;
	logic [CH_W-1:0] cv_s1;
	logic [FC_W-1:0] fc;
	logic [UNIT_W-1:0] one_minus_s;
	logic [CV_W-1:0] v255;

	// stage 2
	logic valid_s2;
	sector_t sector_s2;
	logic [VA_W-1:0] vq_s2;
	logic [VA_W-1:0] vt_s2;
	logic [CH_W-1:0] cv_s2;
	logic [CH_W-1:0] cp_s2;
	logic [A_W-1:0] aq;
	logic [A_W-1:0] at;
	logic [VP_W+CH_W-1:0] vp255;

	// stage 3
	logic [VA_W+CH_W-1:0] vq255;
	logic [VA_W+CH_W-1:0] vt255;
	logic [CH_W-1:0] cq;
	logic [CH_W-1:0] ct;

	assign pop = !q_status.empty;

	assign fc = FC_W'(F_ONE) - FC_W'(head_item.frac);
	assign one_minus_s = UNIT_W'(ONE) - head_item.sat;
	assign v255 = (CV_W'(head_item.val) << CH_W) - CV_W'(head_item.val);

	assign aq = LEVEL_ONE - A_W'(sf_s1);
	assign at = LEVEL_ONE - A_W'(sg_s1);
	assign vp255 = ((VP_W + CH_W)'(vp_s1) << CH_W) - (VP_W + CH_W)'(vp_s1);

	// times 255 as shift and subtract, then keep the integer part
	assign vq255 = ((VA_W + CH_W)'(vq_s2) << CH_W) - (VA_W + CH_W)'(vq_s2);
	assign vt255 = ((VA_W + CH_W)'(vt_s2) << CH_W) - (VA_W + CH_W)'(vt_s2);
	assign cq = vq255[LEVEL_SHIFT+CH_W-1:LEVEL_SHIFT];
	assign ct = vt255[LEVEL_SHIFT+CH_W-1:LEVEL_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= head_item.sector;
		val_s1 <= head_item.val;
		sf_s1 <= SF_W'(head_item.sat) * SF_W'(head_item.frac);
		sg_s1 <= SG_W'(head_item.sat) * SG_W'(fc);
		vp_s1 <= VP_W'(head_item.val) * VP_W'(one_minus_s);
		cv_s1 <= v255[FRAC_BITS+CH_W-1:FRAC_BITS];

		sector_s2 <= sector_s1;
		vq_s2 <= VA_W'(val_s1) * VA_W'(aq);
		vt_s2 <= VA_W'(val_s1) * VA_W'(at);
		cv_s2 <= cv_s1;
		cp_s2 <= vp255[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

		unique case (sector_s2)
			SEC_Y_TO_G: begin
				red <= cq;
				green <= cv_s2;
				blue <= cp_s2;
			end
			SEC_G_TO_C: begin
				red <= cp_s2;
				green <= cv_s2;
				blue <= ct;
			end
			SEC_C_TO_B: begin
				red <= cp_s2;
				green <= cq;
				blue <= cv_s2;
			end
			SEC_B_TO_M: begin
				red <= ct;
				green <= cp_s2;
				blue <= cv_s2;
			end
			SEC_M_TO_R: begin
				red <= cv_s2;
				green <= cp_s2;
				blue <= cq;
			end
			default: begin
				red <= cv_s2;
				green <= ct;
				blue <= cp_s2;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/hsv_to_rgb_pixel_top.sv =====
// hsv to rgb pixel converter, top level
// path: front register, queue entry, back end stage 1 and stage 2 registers, then the output registers with done high
// throughput: one request per clock while busy is low, set by the three-stage back end multiplier pipeline
// busy stays low in steady flow since the back end drains the queue every cycle
// reset (arst_n low) clears the queue, all valid flags and done; no stored pixel state
`default_nettype none
module hsv_to_rgb_pixel_top
	import hsv2rgb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [HUE_W-1:0]       hue_degrees,
	input  wire logic signed [SV_W-1:0] saturation,
	input  wire logic signed [SV_W-1:0] brightness,
	output logic                        done,
	output logic [CH_W-1:0]             red,
	output logic [CH_W-1:0]             green,
	output logic [CH_W-1:0]             blue
);

	q_status_t q_status;
	logic push;
	logic pop;
	item_t push_item;
	item_t head_item;

	hsv2rgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue_degrees(hue_degrees),
		.saturation (saturation),
		.brightness (brightness),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	hsv2rgb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head_item(head_item),
		.status   (q_status)
	);

	hsv2rgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head_item(head_item),
		.pop      (pop),
		.done     (done),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

endmodule
`default_nettype wire
